// ===== design/vrr_pkg.sv =====
`default_nettype none
package vrr_pkg;

    localparam int VER_W     = 64;
    localparam int ID_W      = 32;
    localparam int TYPE_W    = 16;
    localparam int TIME_W    = 32;
    localparam int LIMIT_W   = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [TIME_W-1:0] TIME_OPEN = '1;

    typedef enum logic [1:0] {
        ST_EMITTED  = 2'd0,
        ST_BUFFERED = 2'd1,
        ST_REJECTED = 2'd2,
        ST_STALE    = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORDERED_MODE = 1'b0,
        CFG_BUFFER_LIMIT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [VER_W-1:0]  seq_version;
        logic [ID_W-1:0]   src_vertex;
        logic [ID_W-1:0]   dst_vertex;
        logic [TYPE_W-1:0] link_code;
        logic [TIME_W-1:0] valid_start;
        logic              is_delete;
    } event_t;

    // edge record as held in the store
    typedef struct packed {
        logic [ID_W-1:0]   src_vertex;
        logic [ID_W-1:0]   dst_vertex;
        logic [TYPE_W-1:0] link_code;
        logic [TIME_W-1:0] valid_start;
        logic              is_delete;
    } payload_t;

    typedef struct packed {
        status_t           status;
        logic              has_edge;
        logic [ID_W-1:0]   out_entity;
        logic [ID_W-1:0]   out_target;
        logic [TYPE_W-1:0] out_type;
        logic [TIME_W-1:0] out_from;
        logic [TIME_W-1:0] out_to;
        logic [VER_W-1:0]  out_version;
        logic              last;
    } result_t;

    function automatic payload_t event_payload(input event_t ev);
        payload_t p;
        p.src_vertex  = ev.src_vertex;
        p.dst_vertex  = ev.dst_vertex;
        p.link_code   = ev.link_code;
        p.valid_start = ev.valid_start;
        p.is_delete   = ev.is_delete;
        return p;
    endfunction

    function automatic result_t make_edge(input logic [VER_W-1:0] ver, input payload_t p,
                                          input logic is_last);
        result_t r;
        r.status      = ST_EMITTED;
        r.has_edge    = 1'b1;
        r.out_entity  = p.src_vertex;
        r.out_target  = p.dst_vertex;
        r.out_type    = p.link_code;
        r.out_from    = p.valid_start;
        r.out_to      = p.is_delete ? p.valid_start : TIME_OPEN;
        r.out_version = ver;
        r.last        = is_last;
        return r;
    endfunction

    function automatic result_t make_status(input status_t st, input logic [VER_W-1:0] ver);
        result_t r;
        r             = '0;
        r.status      = st;
        r.out_version = ver;
        r.last        = 1'b1;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== design/vrr_front.sv =====
`default_nettype none
module vrr_front
    import vrr_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   start,
    output logic        busy,
    input  wire event_t item,
    input  wire logic   pop,
    output logic        avail,
    output event_t      head
);

    localparam int QD = 2;

    event_t     q_reg [QD];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;

    assign busy  = (count_reg == 2'(QD));
    assign avail = (count_reg != 2'd0);
    assign push  = start && !busy;
    assign head  = q_reg[rd_ptr_reg];

    // track fill level
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    // advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    // hold queued transactions
    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= item;
    end

endmodule
`default_nettype wire

// ===== design/vrr_back.sv =====
`default_nettype none
module vrr_back
    import vrr_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               ordered_mode,
    input  wire logic [LIMIT_W-1:0] buffer_limit,
    input  wire logic               avail,
    input  wire event_t             head,
    output logic                    pop,
    output logic                    result_valid,
    output result_t                 result
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int LW    = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_DECIDE,
        S_DSEARCH,
        S_DFETCH,
        S_DLOAD
    } state_t;

    state_t            state_reg;
    event_t            cur_reg;
    logic [VER_W-1:0]  applied_reg;
    logic [DEPTH-1:0]  valid_reg;
    logic [VER_W-1:0]  slot_ver_reg [DEPTH];
    logic [CNT_W-1:0]  used_reg;
    logic              hit_any_reg;
    logic [IDX_W-1:0]  hit_idx_reg;
    logic              free_any_reg;
    logic [IDX_W-1:0]  free_idx_reg;
    logic              is_next_reg;
    logic              is_stale_reg;
    result_t           pend_reg;
    logic              res_valid_reg;
    result_t           res_reg;
    payload_t          mem [DEPTH];
    payload_t          rd_reg;

    logic [VER_W-1:0]  next_ver;
    logic [VER_W-1:0]  key;
    logic [DEPTH-1:0]  match_vec;
    logic [IDX_W-1:0]  match_idx;
    logic [IDX_W-1:0]  free_idx;
    logic [LW-1:0]     limit_sat;
    logic              full;
    logic              decide_done;
    logic              store_wr;
    logic [IDX_W-1:0]  wr_idx;
    result_t           decide_result;
    result_t           drain_result;

    assign next_ver = applied_reg + 64'd1;
    assign key      = (state_reg == S_LOOK) ? cur_reg.seq_version : next_ver;

    // compare every slot against the lookup key
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
            match_vec[i] = valid_reg[i] && (slot_ver_reg[i] == key);
    end

    // lowest matching slot and lowest free slot
    always_comb
    begin
        match_idx = '0;
        free_idx  = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (match_vec[i])
                match_idx = IDX_W'(i);
            if (!valid_reg[i])
                free_idx = IDX_W'(i);
        end
    end

    // saturate the limit to the store size
    assign limit_sat = (LW'(buffer_limit) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(buffer_limit);
    assign full      = (LW'(used_reg) >= limit_sat) || !free_any_reg;

    assign decide_done = ordered_mode || !is_next_reg;
    assign store_wr    = (state_reg == S_DECIDE) && !ordered_mode && !is_next_reg &&
                         !is_stale_reg && (hit_any_reg || !full);
    assign wr_idx      = hit_any_reg ? hit_idx_reg : free_idx_reg;

    // take the next transaction from the queue when the engine frees up
    assign pop = avail && ((state_reg == S_IDLE) ||
                           (state_reg == S_DECIDE && decide_done) ||
                           (state_reg == S_DFETCH && !hit_any_reg));

    // classify the current event
    always_comb
    begin
        if (ordered_mode)
            decide_result = make_edge(cur_reg.seq_version, event_payload(cur_reg), 1'b1);
        else if (is_stale_reg)
            decide_result = make_status(ST_STALE, cur_reg.seq_version);
        else if (hit_any_reg || !full)
            decide_result = make_status(ST_BUFFERED, cur_reg.seq_version);
        else
            decide_result = make_status(ST_REJECTED, cur_reg.seq_version);
    end

    // mark the released record final when no further slot follows
    always_comb
    begin
        drain_result      = pend_reg;
        drain_result.last = !hit_any_reg;
    end

    // sequence lookup, decision and drain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            applied_reg   <= '0;
            valid_reg     <= '0;
            used_reg      <= '0;
            hit_any_reg   <= 1'b0;
            hit_idx_reg   <= '0;
            free_any_reg  <= 1'b0;
            free_idx_reg  <= '0;
            is_next_reg   <= 1'b0;
            is_stale_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            res_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (avail)
                        state_reg <= S_LOOK;
                end
                S_LOOK:
                begin
                    hit_any_reg  <= |match_vec;
                    hit_idx_reg  <= match_idx;
                    free_any_reg <= ~&valid_reg;
                    free_idx_reg <= free_idx;
                    is_next_reg  <= (cur_reg.seq_version == next_ver);
                    is_stale_reg <= (cur_reg.seq_version <= applied_reg);
                    state_reg    <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    if (ordered_mode || is_next_reg)
                        applied_reg <= cur_reg.seq_version;
                    if (decide_done)
                    begin
                        res_valid_reg <= 1'b1;
                        res_reg       <= decide_result;
                        state_reg     <= avail ? S_LOOK : S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_DSEARCH;
                    end
                    if (store_wr && !hit_any_reg)
                    begin
                        valid_reg[free_idx_reg] <= 1'b1;
                        used_reg                <= used_reg + CNT_W'(1);
                    end
                end
                S_DSEARCH:
                begin
                    hit_any_reg <= |match_vec;
                    hit_idx_reg <= match_idx;
                    state_reg   <= S_DFETCH;
                end
                S_DFETCH:
                begin
                    res_valid_reg <= 1'b1;
                    res_reg       <= drain_result;
                    if (hit_any_reg)
                    begin
                        valid_reg[hit_idx_reg] <= 1'b0;
                        used_reg               <= used_reg - CNT_W'(1);
                        applied_reg            <= next_ver;
                        state_reg              <= S_DLOAD;
                    end
                    else
                    begin
                        state_reg <= avail ? S_LOOK : S_IDLE;
                    end
                end
                S_DLOAD:
                begin
                    state_reg <= S_DSEARCH;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // hold event data, store contents and the pending edge record
    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= head;
        if (store_wr)
        begin
            slot_ver_reg[wr_idx] <= cur_reg.seq_version;
            mem[wr_idx]          <= event_payload(cur_reg);
        end
        if (state_reg == S_DFETCH)
            rd_reg <= mem[hit_idx_reg];
        if (state_reg == S_DECIDE)
            pend_reg <= make_edge(cur_reg.seq_version, event_payload(cur_reg), 1'b1);
        if (state_reg == S_DLOAD)
            pend_reg <= make_edge(applied_reg, rd_reg, 1'b1);
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule
`default_nettype wire

// ===== design/version_reorder_release_unit.sv =====
// Buffered, rejected, stale and ordered-mode results are strobed from the decide state; an
//   in-order release is strobed from the fetch state, after a slot search.
// An out-of-order transaction passes lookup and decide; an in-order one also passes slot
//   search and fetch, and every held record released behind it adds a load, search and fetch.
// Reset clears the applied version and the slot valid bits and resets the configuration
//   (buffered mode, limit 16). Results are strobed for one cycle and cannot be stalled.
`default_nettype none
module version_reorder_release_unit
    import vrr_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire event_t               item,
    output logic                      result_valid,
    output result_t                   result,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [LIMIT_W-1:0]   cfg_data
);

    logic               ordered_mode_reg;
    logic [LIMIT_W-1:0] buffer_limit_reg;
    logic               pop;
    logic               avail;
    event_t             head;

    assign cfg_ready = 1'b1;

    // write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ordered_mode_reg <= 1'b0;
            buffer_limit_reg <= LIMIT_W'(16);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ORDERED_MODE: ordered_mode_reg <= cfg_data[0];
                CFG_BUFFER_LIMIT: buffer_limit_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    vrr_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .item  (item),
        .pop   (pop),
        .avail (avail),
        .head  (head)
    );

    vrr_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .ordered_mode (ordered_mode_reg),
        .buffer_limit (buffer_limit_reg),
        .avail        (avail),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
`default_nettype wire

// ===== design/vrr_checker.sv =====
`default_nettype none
module vrr_checker
    import vrr_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    result_valid,
    input wire result_t result
);

    // status-only results end their transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.has_edge |-> result.last)
        else $error("status result without last");

    // edge records and the emitted status go together
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.has_edge == (result.status == ST_EMITTED)))
        else $error("edge flag and status disagree");

    // validity end is open or equal to the start
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.has_edge |->
            (result.out_to == result.out_from || result.out_to == TIME_OPEN))
        else $error("bad validity end");

    // a drained record is followed, after the load, search and fetch steps, by the next version
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |-> ##3 (result_valid && result.has_edge &&
            result.out_version == $past(result.out_version, 3) + 64'd1))
        else $error("drain sequence broken");

endmodule

bind version_reorder_release_unit vrr_checker u_vrr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result       (result)
);
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
    import vrr_pkg::*;

    localparam int SLOTS         = 16;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 60;
    localparam int RANDOM_ITEMS  = 130;
    localparam int CALM_AFTER    = 105;
    localparam int CYCLE_LIMIT   = 400000;

    typedef enum logic {
        OP_EVENT   = 1'b0,
        OP_SETTING = 1'b1
    } op_kind_t;

    typedef struct packed {
        op_kind_t           kind;
        event_t             ev;
        cfg_index_t         idx;
        logic [LIMIT_W-1:0] data;
        logic               calm;
    } pending_op_t;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    logic                 busy;
    event_t               item      = '0;
    logic                 result_valid;
    result_t              result;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [LIMIT_W-1:0]   cfg_data  = '0;

    // stimulus and scoreboard
    pending_op_t          pending_ops[$];
    result_t              due_results[$];
    logic [VER_W-1:0]     pool[$];
    int                   quiet_cycles = 0;
    int                   mismatches   = 0;
    int                   rand_events  = 0;
    int                   cycle_count  = 0;
    int                   gap_left     = 0;
    bit                   bursty       = 1'b1;
    bit                   item_calm    = 1'b0;
    bit                   tail_calm    = 1'b0;

    // predictor state
    logic                 mode_ordered = 1'b0;
    logic [LIMIT_W-1:0]   hold_limit   = 5'd16;
    logic [VER_W-1:0]     applied_ver  = '0;
    logic                 slot_used[SLOTS];
    logic [VER_W-1:0]     slot_ver[SLOTS];
    payload_t             slot_rec[SLOTS];

    version_reorder_release_unit #(.DEPTH(SLOTS)) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic result_t edge_record(input logic [VER_W-1:0] ver, input payload_t rec,
                                            input logic fin);
        result_t r;
        r.status      = ST_EMITTED;
        r.has_edge    = 1'b1;
        r.out_entity  = rec.src_vertex;
        r.out_target  = rec.dst_vertex;
        r.out_type    = rec.link_code;
        r.out_from    = rec.valid_start;
        r.out_to      = rec.is_delete ? rec.valid_start : {TIME_W{1'b1}};
        r.out_version = ver;
        r.last        = fin;
        return r;
    endfunction

    function automatic result_t status_record(input status_t st, input logic [VER_W-1:0] ver);
        result_t r;
        r             = '0;
        r.status      = st;
        r.out_version = ver;
        r.last        = 1'b1;
        return r;
    endfunction

    function automatic int find_slot(input logic [VER_W-1:0] ver);
        int i;
        for (i = 0; i < SLOTS; i++)
            if (slot_used[i] && slot_ver[i] == ver)
                return i;
        return -1;
    endfunction

    // work out the results of one accepted event and advance the predicted state
    task automatic predict_release(input event_t ev);
        payload_t         rec;
        result_t          r;
        logic [VER_W-1:0] follow;
        int               hit;
        int               free_slot;
        int               used;
        int               cap;
        int               i;
        rec.src_vertex  = ev.src_vertex;
        rec.dst_vertex  = ev.dst_vertex;
        rec.link_code   = ev.link_code;
        rec.valid_start = ev.valid_start;
        rec.is_delete   = ev.is_delete;
        follow = applied_ver + 64'd1;
        if (mode_ordered) begin
            due_results.insert(due_results.size(), edge_record(ev.seq_version, rec, 1'b1));
            applied_ver = ev.seq_version;
        end
        else if (ev.seq_version == follow) begin
            r = edge_record(ev.seq_version, rec, 1'b1);
            applied_ver = ev.seq_version;
            // release held records while they stay consecutive
            follow = applied_ver + 64'd1;
            hit = find_slot(follow);
            while (hit >= 0) begin
                r.last = 1'b0;
                due_results.insert(due_results.size(), r);
                r = edge_record(slot_ver[hit], slot_rec[hit], 1'b1);
                applied_ver = slot_ver[hit];
                slot_used[hit] = 1'b0;
                follow = applied_ver + 64'd1;
                hit = find_slot(follow);
            end
            due_results.insert(due_results.size(), r);
        end
        else if (ev.seq_version <= applied_ver) begin
            due_results.insert(due_results.size(), status_record(ST_STALE, ev.seq_version));
        end
        else begin
            hit = find_slot(ev.seq_version);
            if (hit < 0) begin
                cap = (hold_limit > SLOTS) ? SLOTS : int'(hold_limit);
                used = 0;
                free_slot = -1;
                for (i = 0; i < SLOTS; i++) begin
                    if (slot_used[i])
                        used++;
                    else if (free_slot < 0)
                        free_slot = i;
                end
                if (used < cap && free_slot >= 0)
                    hit = free_slot;
            end
            if (hit < 0) begin
                due_results.insert(due_results.size(),
                                   status_record(ST_REJECTED, ev.seq_version));
            end
            else begin
                slot_used[hit] = 1'b1;
                slot_ver[hit]  = ev.seq_version;
                slot_rec[hit]  = rec;
                due_results.insert(due_results.size(),
                                   status_record(ST_BUFFERED, ev.seq_version));
            end
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // monitor: check results, track settings, predict accepted transactions
    always @(posedge clk)
    begin
        result_t want;
        logic    took;
        if (rst_n) begin
            took = start && !busy;
            if (result_valid) begin
                if (due_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with nothing expected, version %0h", $time,
                             result.out_version);
                end
                else begin
                    want = due_results.pop_front();
                    check_field("status", 64'(want.status), 64'(result.status));
                    check_field("has_edge", 64'(want.has_edge), 64'(result.has_edge));
                    check_field("out_entity", 64'(want.out_entity), 64'(result.out_entity));
                    check_field("out_target", 64'(want.out_target), 64'(result.out_target));
                    check_field("out_type", 64'(want.out_type), 64'(result.out_type));
                    check_field("out_from", 64'(want.out_from), 64'(result.out_from));
                    check_field("out_to", 64'(want.out_to), 64'(result.out_to));
                    check_field("out_version", want.out_version, result.out_version);
                    check_field("last", 64'(want.last), 64'(result.last));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index_t'(cfg_index))
                    CFG_ORDERED_MODE: mode_ordered = cfg_data[0];
                    CFG_BUFFER_LIMIT: hold_limit = cfg_data;
                    default: ;
                endcase
            end
            if (took)
                predict_release(item);
            if (due_results.size() == 0 && !took)
                quiet_cycles <= (quiet_cycles < 1000) ? quiet_cycles + 1 : quiet_cycles;
            else
                quiet_cycles <= 0;
        end
    end

    // driver: present pending transactions, with bursts of idle cycles
    always @(posedge clk)
    begin
        pending_op_t op;
        logic        took_item;
        logic        took_cfg;
        logic        drive_start;
        logic        drive_cfg;
        if (rst_n) begin
            took_item   = start && !busy;
            took_cfg    = cfg_valid && cfg_ready;
            drive_start = start && !took_item;
            drive_cfg   = cfg_valid && !took_cfg;
            if (took_item) begin
                if (!item_calm && bursty && $urandom_range(0, 1) == 1)
                    gap_left = $urandom_range(1, 18);
                if ($urandom_range(0, 15) == 0)
                    bursty = !bursty;
            end
            if (!drive_start && !drive_cfg) begin
                if (gap_left > 0) begin
                    gap_left--;
                end
                else if (pending_ops.size() != 0) begin
                    op = pending_ops[0];
                    if (op.kind == OP_EVENT) begin
                        void'(pending_ops.pop_front());
                        item        <= op.ev;
                        item_calm    = op.calm;
                        drive_start  = 1'b1;
                    end
                    else if (!took_item && quiet_cycles >= SETTLE_CYCLES) begin
                        // settings change only once the block has gone quiet
                        void'(pending_ops.pop_front());
                        cfg_index <= op.idx;
                        cfg_data  <= op.data;
                        drive_cfg  = 1'b1;
                    end
                end
            end
            start     <= drive_start;
            cfg_valid <= drive_cfg;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    function automatic event_t random_event(input logic [VER_W-1:0] ver);
        event_t ev;
        ev.seq_version = ver;
        ev.src_vertex  = $urandom;
        ev.dst_vertex  = $urandom;
        ev.link_code   = 16'($urandom_range(0, 16'hFFFF));
        ev.valid_start = $urandom;
        ev.is_delete   = 1'($urandom_range(0, 1));
        return ev;
    endfunction

    task automatic push_event(input event_t ev);
        pending_op_t op;
        op      = '0;
        op.kind = OP_EVENT;
        op.ev   = ev;
        op.calm = tail_calm;
        pending_ops.insert(pending_ops.size(), op);
        rand_events++;
    endtask

    task automatic push_setting(input cfg_index_t idx, input logic [LIMIT_W-1:0] val);
        pending_op_t op;
        op      = '0;
        op.kind = OP_SETTING;
        op.idx  = idx;
        op.data = val;
        pending_ops.insert(pending_ops.size(), op);
    endtask

    // hold the sender until every queued transaction has finished
    task automatic wait_quiet();
        while (pending_ops.size() != 0 || start || cfg_valid || quiet_cycles < 2)
            @(negedge clk);
    endtask

    // send the pooled versions in random order, mixed with stale and repeated ones
    task automatic emit_pool(input logic [VER_W-1:0] lo, input int span,
                             input logic [VER_W-1:0] floor_ver, input bit wild);
        int               pos;
        logic [VER_W-1:0] noise_ver;
        while (pool.size() != 0) begin
            if (span > 0 && $urandom_range(0, 4) == 0) begin
                case ($urandom_range(0, 2))
                    0: noise_ver = floor_ver - 64'($urandom_range(0, 40));
                    1: noise_ver = lo + 64'($urandom_range(0, span - 1));
                    default: noise_ver = wild ? {$urandom, $urandom}
                                              : lo + 64'($urandom_range(0, span - 1));
                endcase
                push_event(random_event(noise_ver));
            end
            pos = $urandom_range(0, pool.size() - 1);
            push_event(random_event(pool[pos]));
            pool.delete(pos);
        end
    endtask

    initial
    begin
        event_t             ev;
        logic [VER_W-1:0]   base;
        logic [VER_W-1:0]   floor_ver;
        logic [LIMIT_W-1:0] gen_limit;
        int                 held;
        int                 room;
        int                 n;
        int                 k;
        int                 j;
        int                 pick;
        bit                 burst_done;

        for (k = 0; k < SLOTS; k++)
            slot_used[k] = 1'b0;

        // directed: field extremes, overwrite, stale, small store
        push_setting(CFG_ORDERED_MODE, 5'd0);
        push_setting(CFG_BUFFER_LIMIT, 5'd16);
        ev = random_event(64'd1);
        ev.src_vertex  = '1;
        ev.dst_vertex  = '0;
        ev.link_code   = '1;
        ev.valid_start = '1;
        ev.is_delete   = 1'b0;
        push_event(ev);
        ev = random_event(64'd3);
        ev.src_vertex  = '0;
        ev.dst_vertex  = '1;
        ev.link_code   = '0;
        ev.valid_start = '0;
        ev.is_delete   = 1'b1;
        push_event(ev);
        ev = random_event(64'd5);
        ev.is_delete = 1'b1;
        push_event(ev);
        push_event(random_event(64'd4));
        push_event(random_event(64'd4));
        push_event(random_event(64'd1));
        push_event(random_event(64'd2));
        push_setting(CFG_BUFFER_LIMIT, 5'd2);
        push_event(random_event(64'd8));
        push_event(random_event(64'd9));
        push_event(random_event(64'd10));
        push_event(random_event(64'd9));
        push_event(random_event(64'd6));
        push_event(random_event(64'd7));
        push_setting(CFG_BUFFER_LIMIT, 5'd0);
        push_event(random_event(64'd11));
        push_event(random_event(64'd10));
        // ordered mode leaves a held record behind, then wrap past all ones
        push_setting(CFG_BUFFER_LIMIT, 5'd16);
        push_event(random_event(64'd12));
        push_setting(CFG_ORDERED_MODE, 5'd1);
        push_event(random_event(64'd40));
        push_event(random_event(64'd7));
        push_event(random_event(64'hFFFF_FFFF_FFFF_FFFD));
        push_setting(CFG_ORDERED_MODE, 5'd0);
        push_event(random_event(64'hFFFF_FFFF_FFFF_FFFF));
        push_event(random_event(64'd0));
        push_event(random_event(64'hFFFF_FFFF_FFFF_FFFE));
        push_event(random_event(64'd0));
        // move the applied version back so the stale held record drains again
        push_setting(CFG_ORDERED_MODE, 5'd1);
        push_event(random_event(64'd10));
        push_setting(CFG_ORDERED_MODE, 5'd0);
        push_event(random_event(64'd11));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        gen_limit   = 5'd16;
        burst_done  = 1'b0;
        while (rand_events < RANDOM_ITEMS) begin
            wait_quiet();
            tail_calm = (rand_events >= CALM_AFTER);
            floor_ver = applied_ver;
            base      = applied_ver + 64'd1;
            held      = 0;
            for (k = 0; k < SLOTS; k++)
                if (slot_used[k])
                    held++;
            room = ((gen_limit > SLOTS) ? SLOTS : int'(gen_limit)) - held;
            if (room < 0)
                room = 0;
            pick = $urandom_range(0, 9);
            if (!burst_done) begin
                // fill the whole store, overflow it once, then release everything
                burst_done = 1'b1;
                gen_limit  = 5'd31;
                push_setting(CFG_BUFFER_LIMIT, gen_limit);
                room = SLOTS - held;
                for (k = 1; k <= room; k++)
                    pool.insert(pool.size(), base + 64'(k));
                emit_pool(base, 0, floor_ver, 1'b0);
                push_event(random_event(base + 64'(room) + 64'd1));
                push_event(random_event(base));
            end
            else if (pick <= 1) begin
                case ($urandom_range(0, 7))
                    0: gen_limit = 5'd0;
                    1: gen_limit = 5'd1;
                    2: gen_limit = 5'd2;
                    3: gen_limit = 5'd4;
                    4: gen_limit = 5'd16;
                    5: gen_limit = 5'd17;
                    6: gen_limit = 5'd31;
                    default: gen_limit = 5'($urandom_range(0, 31));
                endcase
                push_setting(CFG_BUFFER_LIMIT, gen_limit);
            end
            else if (pick == 2) begin
                // ordered stretch, ending at or slightly below the current version
                push_setting(CFG_ORDERED_MODE, 5'd1);
                n = $urandom_range(2, 6);
                for (j = 0; j < n; j++) begin
                    if ($urandom_range(0, 1) == 1)
                        push_event(random_event({$urandom, $urandom}));
                    else
                        push_event(random_event(base + 64'($urandom_range(0, 20))));
                end
                push_event(random_event(floor_ver - 64'($urandom_range(0, 3))));
                push_setting(CFG_ORDERED_MODE, 5'd0);
            end
            else begin
                // shuffled windows of consecutive versions, back to back
                repeat ($urandom_range(1, 3)) begin
                    n = $urandom_range(1, (room + 1 < 6) ? room + 1 : 6);
                    if ($urandom_range(0, 5) == 0)
                        n = $urandom_range(1, room + 2);
                    for (k = 0; k < n; k++)
                        pool.insert(pool.size(), base + 64'(k));
                    emit_pool(base, n, floor_ver, gen_limit == 0);
                    base = base + 64'(n);
                end
            end
        end

        wait_quiet();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (due_results.size() != 0)
            $display("%0t: %0d expected results never arrived", $time, due_results.size());
        if (mismatches == 0 && due_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
